// ----- hw/rtl/gsea_pkg.sv -----
// Shared constants, types and state encoding for the enrichment score block.
// Depends on nothing; used by gsea_div and gene_set_enrichment_score.
package gsea_pkg;

  localparam int SET_DEPTH  = 64;
  localparam int GENE_DEPTH = 1024;

  localparam int SET_AW  = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int SET_CW  = $clog2(SET_DEPTH + 1);
  localparam int GENE_AW = $clog2(GENE_DEPTH);
  localparam int GENE_CW = $clog2(GENE_DEPTH + 1);
  localparam int MT_W    = $clog2(SET_DEPTH * GENE_DEPTH + 1);
  localparam int DEN_W   = MT_W + 1;

  localparam int ID_W   = 32;
  localparam int WT_W   = 32;
  localparam int WSUM_W = 48;
  localparam int DIV_W  = 48;
  localparam int QUOT_W = DIV_W + 2;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_ZERO_SUM = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD, S_G_RD, S_SCAN, S_G_END, S_P_DIV, S_P2_RD, S_P2_CHK,
    S_P2_DIV, S_P2_UPD, S_P2_MAX, S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- hw/rtl/gsea_div.sv -----
// Shared restoring divider, one quotient bit per cycle, sign applied at the end.
// Depends on gsea_pkg.
module gsea_div (
  input  logic               clk,
  input  logic               rst,
  input  gsea_pkg::div_req_t req,
  output gsea_pkg::div_rsp_t rsp
);

  logic                        busy;
  logic                        done;
  logic                        neg;
  logic [gsea_pkg::DCNT_W-1:0] cnt;
  logic [gsea_pkg::DIV_W-1:0]  rem;
  logic [gsea_pkg::DIV_W-1:0]  dvd;
  logic [gsea_pkg::DIV_W-1:0]  den;
  logic [gsea_pkg::DIV_W:0]    rem_sh;
  logic                        ge;
  logic [gsea_pkg::DIV_W-1:0]  rem_next;

  always_comb begin
    rem_sh   = {rem, dvd[gsea_pkg::DIV_W-1]};
    ge       = rem_sh >= {1'b0, den};
    rem_next = ge ? gsea_pkg::DIV_W'(rem_sh - {1'b0, den})
                  : rem_sh[gsea_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= req.num;
        den  <= req.den;
        neg  <= req.neg;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[gsea_pkg::DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == gsea_pkg::DCNT_W'(gsea_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    rsp.quot = neg ? -$signed({2'b00, dvd}) : $signed({2'b00, dvd});
  end

  assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a division in flight");

endmodule

// ----- hw/rtl/gene_set_enrichment_score.sv -----
// Gene-set enrichment score: weighted running-sum maximum over a ranked list.
// Depends on gsea_pkg and gsea_div.
// The final ranked gene starts a run: a match scan of every gene against the members, the penalty
// divide, then a score update per gene, with a divide for each matched gene while the weight sum
// is nonzero. Throughput: one load per cycle, none in a run.
// Reset (synchronous, active high) empties both lists, clears the sums and drops out_valid.
module gene_set_enrichment_score (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [gsea_pkg::ID_W-1:0]           gene_id,
  input  logic signed [gsea_pkg::WT_W-1:0]    weight,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  score,
  output logic [gsea_pkg::GENE_CW-1:0]        annotated_count,
  output logic [1:0]                          status
);

  // Member IDs, ranked IDs, ranked weights and the per-gene match flag are
  // memories with one write port and one registered read port.
  logic [gsea_pkg::ID_W-1:0]        member_ids [gsea_pkg::SET_DEPTH];
  logic [gsea_pkg::ID_W-1:0]        ranked_ids [gsea_pkg::GENE_DEPTH];
  logic signed [gsea_pkg::WT_W-1:0] ranked_weights [gsea_pkg::GENE_DEPTH];
  logic                             match_flags [gsea_pkg::GENE_DEPTH];

  logic [gsea_pkg::ID_W-1:0]        member_q;
  logic [gsea_pkg::ID_W-1:0]        rid_q;
  logic signed [gsea_pkg::WT_W-1:0] rw_q;
  logic                             flag_q;

  gsea_pkg::state_t state;
  gsea_pkg::state_t state_next;

  logic [gsea_pkg::SET_CW-1:0]         member_count;
  logic [gsea_pkg::GENE_CW-1:0]        ranked_count;
  logic [gsea_pkg::GENE_CW-1:0]        gi;
  logic [gsea_pkg::SET_CW-1:0]         mj;
  logic [gsea_pkg::SET_CW-1:0]         gene_matches;
  logic                                cmp_valid;
  logic signed [gsea_pkg::WSUM_W-1:0]  weight_sum;
  logic [gsea_pkg::MT_W-1:0]           match_total;
  logic signed [gsea_pkg::QUOT_W-1:0]  penalty;
  logic signed [gsea_pkg::QUOT_W-1:0]  delta;
  logic signed [31:0]                  running_sum;
  logic signed [31:0]                  running_max;
  logic [gsea_pkg::GENE_CW-1:0]        annotated;

  logic                                accept;
  logic                                issue;
  logic                                scan_end;
  logic                                pass1_done;
  logic                                p2_done;
  logic signed [gsea_pkg::DEN_W-1:0]   denom;
  logic [gsea_pkg::DEN_W-1:0]          denom_mag;
  logic [gsea_pkg::WT_W-1:0]           w_mag;
  logic [gsea_pkg::WSUM_W-1:0]         wsum_mag;
  logic signed [gsea_pkg::QUOT_W-1:0]  sum_wide;
  logic signed [31:0]                  sum_sat;
  logic                                flag_we;

  gsea_pkg::div_req_t div_req;
  gsea_pkg::div_rsp_t div_rsp;

  gsea_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept     = in_valid && !in_stall;
  assign issue      = (state == gsea_pkg::S_SCAN) && (mj < member_count);
  assign scan_end   = (state == gsea_pkg::S_SCAN) && !issue && !cmp_valid;
  assign pass1_done = (gi == ranked_count);
  assign p2_done    = (gi == ranked_count);

  // N - NH may be negative when duplicate members inflate the match total.
  assign denom     = $signed({1'b0, gsea_pkg::MT_W'(ranked_count)})
                   - $signed({1'b0, match_total});
  assign denom_mag = denom[gsea_pkg::DEN_W-1] ? gsea_pkg::DEN_W'(-denom)
                                               : gsea_pkg::DEN_W'(denom);
  assign w_mag     = rw_q[gsea_pkg::WT_W-1] ? gsea_pkg::WT_W'(-rw_q)
                                             : gsea_pkg::WT_W'(rw_q);
  assign wsum_mag  = weight_sum[gsea_pkg::WSUM_W-1]
                   ? gsea_pkg::WSUM_W'(-weight_sum) : gsea_pkg::WSUM_W'(weight_sum);

  // The running sum saturates to 32 bits after each gene.
  assign sum_wide = gsea_pkg::QUOT_W'(running_sum) + delta;
  always_comb begin
    if (sum_wide > gsea_pkg::QUOT_W'(32'sh7FFF_FFFF)) begin
      sum_sat = 32'sh7FFF_FFFF;
    end else if (sum_wide < -gsea_pkg::QUOT_W'(33'sh0_8000_0000)) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      gsea_pkg::S_LOAD: begin
        if (accept && mode && last) state_next = gsea_pkg::S_G_RD;
      end
      gsea_pkg::S_G_RD: begin
        if (!pass1_done) begin
          state_next = gsea_pkg::S_SCAN;
        end else if (match_total == '0) begin
          state_next = gsea_pkg::S_OUT;
        end else if (denom == '0) begin
          state_next = gsea_pkg::S_P2_RD;
        end else begin
          state_next = gsea_pkg::S_P_DIV;
        end
      end
      gsea_pkg::S_SCAN: begin
        if (scan_end) state_next = gsea_pkg::S_G_END;
      end
      gsea_pkg::S_G_END:  state_next = gsea_pkg::S_G_RD;
      gsea_pkg::S_P_DIV: begin
        if (div_rsp.done) state_next = gsea_pkg::S_P2_RD;
      end
      gsea_pkg::S_P2_RD: begin
        state_next = p2_done ? gsea_pkg::S_OUT : gsea_pkg::S_P2_CHK;
      end
      gsea_pkg::S_P2_CHK: begin
        state_next = (flag_q && weight_sum != '0) ? gsea_pkg::S_P2_DIV
                                                  : gsea_pkg::S_P2_UPD;
      end
      gsea_pkg::S_P2_DIV: begin
        if (div_rsp.done) state_next = gsea_pkg::S_P2_UPD;
      end
      gsea_pkg::S_P2_UPD: state_next = gsea_pkg::S_P2_MAX;
      gsea_pkg::S_P2_MAX: state_next = gsea_pkg::S_P2_RD;
      gsea_pkg::S_OUT: begin
        if (!out_valid) state_next = gsea_pkg::S_LOAD;
      end
      default: state_next = gsea_pkg::S_LOAD;
    endcase
  end

  // Control outputs: the input handshake, the flag write and divider requests.
  always_comb begin
    in_stall      = (state != gsea_pkg::S_LOAD);
    flag_we       = (state == gsea_pkg::S_G_END);
    div_req.start = 1'b0;
    div_req.neg   = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state)
      gsea_pkg::S_G_RD: begin
        div_req.start = pass1_done && (match_total != '0) && (denom != '0);
        div_req.neg   = denom[gsea_pkg::DEN_W-1];
        div_req.num   = gsea_pkg::DIV_W'(65536);
        div_req.den   = gsea_pkg::DIV_W'(denom_mag);
      end
      gsea_pkg::S_P2_CHK: begin
        div_req.start = flag_q && (weight_sum != '0);
        div_req.neg   = rw_q[gsea_pkg::WT_W-1] ^ weight_sum[gsea_pkg::WSUM_W-1];
        div_req.num   = {w_mag, 16'h0000};
        div_req.den   = wsum_mag;
      end
      default: begin
      end
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (accept && !mode && member_count < gsea_pkg::SET_CW'(gsea_pkg::SET_DEPTH)) begin
      member_ids[member_count[gsea_pkg::SET_AW-1:0]] <= gene_id;
    end
    member_q <= member_ids[mj[gsea_pkg::SET_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (accept && mode && ranked_count < gsea_pkg::GENE_CW'(gsea_pkg::GENE_DEPTH)) begin
      ranked_ids[ranked_count[gsea_pkg::GENE_AW-1:0]]     <= gene_id;
      ranked_weights[ranked_count[gsea_pkg::GENE_AW-1:0]] <= weight;
    end
    rid_q <= ranked_ids[gi[gsea_pkg::GENE_AW-1:0]];
    rw_q  <= ranked_weights[gi[gsea_pkg::GENE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      match_flags[gi[gsea_pkg::GENE_AW-1:0]] <= (gene_matches != '0);
    end
    flag_q <= match_flags[gi[gsea_pkg::GENE_AW-1:0]];
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gsea_pkg::S_LOAD;
      member_count <= '0;
      ranked_count <= '0;
      weight_sum   <= '0;
      match_total  <= '0;
      running_sum  <= '0;
      running_max  <= 32'sh8000_0000;
      annotated    <= '0;
      gi           <= '0;
      mj           <= '0;
      cmp_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        gsea_pkg::S_LOAD: begin
          gi <= '0;
          if (accept && !mode && member_count < gsea_pkg::SET_CW'(gsea_pkg::SET_DEPTH)) begin
            member_count <= member_count + 1'b1;
          end
          if (accept && mode && ranked_count < gsea_pkg::GENE_CW'(gsea_pkg::GENE_DEPTH)) begin
            ranked_count <= ranked_count + 1'b1;
          end
        end
        gsea_pkg::S_G_RD: begin
          mj           <= '0;
          gene_matches <= '0;
          if (pass1_done) begin
            gi          <= '0;
            running_sum <= '0;
            running_max <= 32'sh8000_0000;
            annotated   <= '0;
            penalty     <= '0;
          end
        end
        gsea_pkg::S_SCAN: begin
          if (issue) mj <= mj + 1'b1;
          if (cmp_valid && member_q == rid_q) begin
            gene_matches <= gene_matches + 1'b1;
            weight_sum   <= weight_sum + gsea_pkg::WSUM_W'(rw_q);
          end
        end
        gsea_pkg::S_G_END: begin
          match_total <= match_total + gsea_pkg::MT_W'(gene_matches);
          gi          <= gi + 1'b1;
        end
        gsea_pkg::S_P_DIV: begin
          if (div_rsp.done) penalty <= div_rsp.quot;
        end
        gsea_pkg::S_P2_CHK: begin
          if (flag_q) begin
            annotated <= annotated + 1'b1;
            delta     <= '0;
          end else begin
            delta <= -penalty;
          end
        end
        gsea_pkg::S_P2_DIV: begin
          if (div_rsp.done) delta <= div_rsp.quot;
        end
        gsea_pkg::S_P2_UPD: begin
          running_sum <= sum_sat;
        end
        gsea_pkg::S_P2_MAX: begin
          if (running_sum > running_max) running_max <= running_sum;
          gi <= gi + 1'b1;
        end
        gsea_pkg::S_OUT: begin
          if (!out_valid) begin
            // Publish the result and start the next list from empty.
            out_valid <= 1'b1;
            if (match_total == '0) begin
              status          <= gsea_pkg::ST_NO_MATCH;
              score           <= '0;
              annotated_count <= '0;
            end else if (weight_sum == '0) begin
              status          <= gsea_pkg::ST_ZERO_SUM;
              score           <= '0;
              annotated_count <= annotated;
            end else begin
              status          <= gsea_pkg::ST_OK;
              score           <= running_max;
              annotated_count <= annotated;
            end
            member_count <= '0;
            ranked_count <= '0;
            weight_sum   <= '0;
            match_total  <= '0;
            running_sum  <= '0;
            running_max  <= 32'sh8000_0000;
            annotated    <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == gsea_pkg::ST_NO_MATCH |-> score == '0 && annotated_count == '0)
    else $error("no-match result carries a score or count");
  assert property (@(posedge clk) disable iff (rst)
    member_count <= gsea_pkg::SET_CW'(gsea_pkg::SET_DEPTH))
    else $error("member count beyond store depth");
  assert property (@(posedge clk) disable iff (rst)
    annotated <= ranked_count)
    else $error("annotated count exceeds ranked genes");
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> state == gsea_pkg::S_P_DIV || state == gsea_pkg::S_P2_DIV)
    else $error("divider busy outside a divide step");

endmodule
